/* rtl/rti_pkg.sv */
// ----------------------------------------------------------------------------
// rti_pkg
// types, widths and the micro-op program of the ray / triangle tester
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int KIND_W    = 3;
  localparam int DIST_W    = COORD_W - 1;

  // edge and offset vectors, one bit wider than a coordinate
  localparam int E_W     = COORD_W + 1;
  // shared multiplier operands and product
  localparam int MUL_W   = E_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  // cross product components, split at LO_W for the dot products
  localparam int PQ_W    = 2 * E_W + 1;
  localparam int LO_W    = E_W;
  // dot product accumulator with headroom
  localparam int ACC_W   = E_W + PQ_W + 4;
  localparam int SUM_W   = ACC_W + 1;
  localparam int DIV_W   = ACC_W + DIST_W;
  localparam int CNT_W   = $clog2(DIST_W);

  localparam int NUM_UOPS = 36;
  localparam int STEP_W   = $clog2(NUM_UOPS);

  localparam logic [KIND_W-1:0] KIND_ORIGIN = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DIR    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_A      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_B      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_C      = 3'd4;

  // operand sources
  localparam logic [2:0] SRC_D  = 3'd0;
  localparam logic [2:0] SRC_E1 = 3'd1;
  localparam logic [2:0] SRC_E2 = 3'd2;
  localparam logic [2:0] SRC_S  = 3'd3;
  localparam logic [2:0] SRC_P  = 3'd4;
  localparam logic [2:0] SRC_Q  = 3'd5;

  // which part of operand b
  localparam logic [1:0] PART_FULL = 2'd0;
  localparam logic [1:0] PART_LO   = 2'd1;
  localparam logic [1:0] PART_HI   = 2'd2;

  // accumulator destinations
  localparam logic [2:0] DST_NONE = 3'd0;
  localparam logic [2:0] DST_P    = 3'd1;
  localparam logic [2:0] DST_Q    = 3'd2;
  localparam logic [2:0] DST_DET  = 3'd3;
  localparam logic [2:0] DST_UU   = 3'd4;
  localparam logic [2:0] DST_VV   = 3'd5;
  localparam logic [2:0] DST_TT   = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
  } out_t;

  typedef struct packed {
    logic [2:0] src_a;
    logic [1:0] idx_a;
    logic [2:0] src_b;
    logic [1:0] idx_b;
    logic [1:0] part;
    logic       sub;
    logic       clr;
    logic [2:0] dst;
    logic [1:0] idx_d;
  } uop_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic mul;
    logic acc;
    uop_t uop;
    logic norm;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic miss;
    logic sat;
  } stat_t;

  function automatic uop_t mk(input logic [2:0] sa, input logic [1:0] ia,
                              input logic [2:0] sb, input logic [1:0] ib,
                              input logic [1:0] pt, input logic sb_n,
                              input logic cl, input logic [2:0] ds,
                              input logic [1:0] id);
    uop_t u;
    u.src_a = sa; u.idx_a = ia; u.src_b = sb; u.idx_b = ib;
    u.part = pt; u.sub = sb_n; u.clr = cl; u.dst = ds; u.idx_d = id;
    return u;
  endfunction

  // p = d x e2, det = e1.p, uu = s.p, q = s x e1, vv = d.q, tt = e2.q
  function automatic uop_t uop_rom(input logic [STEP_W-1:0] step);
    uop_t u;
    u = '0;
    unique case (step)
      6'd0:  u = mk(SRC_D,  2'd1, SRC_E2, 2'd2, PART_FULL, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd1:  u = mk(SRC_D,  2'd2, SRC_E2, 2'd1, PART_FULL, 1'b1, 1'b0, DST_P,    2'd0);
      6'd2:  u = mk(SRC_D,  2'd2, SRC_E2, 2'd0, PART_FULL, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd3:  u = mk(SRC_D,  2'd0, SRC_E2, 2'd2, PART_FULL, 1'b1, 1'b0, DST_P,    2'd1);
      6'd4:  u = mk(SRC_D,  2'd0, SRC_E2, 2'd1, PART_FULL, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd5:  u = mk(SRC_D,  2'd1, SRC_E2, 2'd0, PART_FULL, 1'b1, 1'b0, DST_P,    2'd2);
      6'd6:  u = mk(SRC_E1, 2'd0, SRC_P,  2'd0, PART_LO,   1'b0, 1'b1, DST_NONE, 2'd0);
      6'd7:  u = mk(SRC_E1, 2'd0, SRC_P,  2'd0, PART_HI,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd8:  u = mk(SRC_E1, 2'd1, SRC_P,  2'd1, PART_LO,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd9:  u = mk(SRC_E1, 2'd1, SRC_P,  2'd1, PART_HI,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd10: u = mk(SRC_E1, 2'd2, SRC_P,  2'd2, PART_LO,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd11: u = mk(SRC_E1, 2'd2, SRC_P,  2'd2, PART_HI,   1'b0, 1'b0, DST_DET,  2'd0);
      6'd12: u = mk(SRC_S,  2'd0, SRC_P,  2'd0, PART_LO,   1'b0, 1'b1, DST_NONE, 2'd0);
      6'd13: u = mk(SRC_S,  2'd0, SRC_P,  2'd0, PART_HI,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd14: u = mk(SRC_S,  2'd1, SRC_P,  2'd1, PART_LO,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd15: u = mk(SRC_S,  2'd1, SRC_P,  2'd1, PART_HI,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd16: u = mk(SRC_S,  2'd2, SRC_P,  2'd2, PART_LO,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd17: u = mk(SRC_S,  2'd2, SRC_P,  2'd2, PART_HI,   1'b0, 1'b0, DST_UU,   2'd0);
      6'd18: u = mk(SRC_S,  2'd1, SRC_E1, 2'd2, PART_FULL, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd19: u = mk(SRC_S,  2'd2, SRC_E1, 2'd1, PART_FULL, 1'b1, 1'b0, DST_Q,    2'd0);
      6'd20: u = mk(SRC_S,  2'd2, SRC_E1, 2'd0, PART_FULL, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd21: u = mk(SRC_S,  2'd0, SRC_E1, 2'd2, PART_FULL, 1'b1, 1'b0, DST_Q,    2'd1);
      6'd22: u = mk(SRC_S,  2'd0, SRC_E1, 2'd1, PART_FULL, 1'b0, 1'b1, DST_NONE, 2'd0);
      6'd23: u = mk(SRC_S,  2'd1, SRC_E1, 2'd0, PART_FULL, 1'b1, 1'b0, DST_Q,    2'd2);
      6'd24: u = mk(SRC_D,  2'd0, SRC_Q,  2'd0, PART_LO,   1'b0, 1'b1, DST_NONE, 2'd0);
      6'd25: u = mk(SRC_D,  2'd0, SRC_Q,  2'd0, PART_HI,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd26: u = mk(SRC_D,  2'd1, SRC_Q,  2'd1, PART_LO,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd27: u = mk(SRC_D,  2'd1, SRC_Q,  2'd1, PART_HI,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd28: u = mk(SRC_D,  2'd2, SRC_Q,  2'd2, PART_LO,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd29: u = mk(SRC_D,  2'd2, SRC_Q,  2'd2, PART_HI,   1'b0, 1'b0, DST_VV,   2'd0);
      6'd30: u = mk(SRC_E2, 2'd0, SRC_Q,  2'd0, PART_LO,   1'b0, 1'b1, DST_NONE, 2'd0);
      6'd31: u = mk(SRC_E2, 2'd0, SRC_Q,  2'd0, PART_HI,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd32: u = mk(SRC_E2, 2'd1, SRC_Q,  2'd1, PART_LO,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd33: u = mk(SRC_E2, 2'd1, SRC_Q,  2'd1, PART_HI,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd34: u = mk(SRC_E2, 2'd2, SRC_Q,  2'd2, PART_LO,   1'b0, 1'b0, DST_NONE, 2'd0);
      6'd35: u = mk(SRC_E2, 2'd2, SRC_Q,  2'd2, PART_HI,   1'b0, 1'b0, DST_TT,   2'd0);
      default: u = '0;
    endcase
    return u;
  endfunction

endpackage

/* rtl/rti_ctrl.sv */
// ----------------------------------------------------------------------------
// rti_ctrl
// sequencer: walks the micro-op program, the divider and the output handshake
// ----------------------------------------------------------------------------
module rti_ctrl
  import rti_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  stat_t             stat,
  output cmd_t              cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_NORM  = 3'd4;
  localparam logic [2:0] S_TEST  = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              accept, out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    step_next    = step;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.uop      = uop_rom(step);
    cmd.load     = accept;
    unique case (state)
      S_IDLE: begin
        if (accept && in_kind == KIND_C) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        step_next  = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (step == STEP_W'(NUM_UOPS - 1)) begin
          state_next = S_NORM;
        end else begin
          step_next  = step + 1'b1;
          state_next = S_MUL;
        end
      end
      S_NORM: begin
        cmd.norm   = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        cmd.div_init = 1'b1;
        cnt_next     = CNT_W'(DIST_W - 1);
        if (stat.miss || stat.sat) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/rti_datapath.sv */
// ----------------------------------------------------------------------------
// rti_datapath
// vector registers, shared multiply-accumulate, hit tests and t divider
// ----------------------------------------------------------------------------
module rti_datapath
  import rti_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  in_t   in_data,
  input  cmd_t  cmd,
  output stat_t stat,
  output out_t  out_data
);

  logic signed [COORD_W-1:0] org [3];
  logic signed [COORD_W-1:0] dir [3];
  logic signed [COORD_W-1:0] va  [3];
  logic signed [COORD_W-1:0] vb  [3];
  logic signed [COORD_W-1:0] vc  [3];
  logic signed [E_W-1:0]     e1  [3];
  logic signed [E_W-1:0]     e2  [3];
  logic signed [E_W-1:0]     s   [3];
  logic signed [PQ_W-1:0]    p   [3];
  logic signed [PQ_W-1:0]    q   [3];

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, acc_next, prod_ext, term;
  logic signed [ACC_W-1:0]  det, uu, vv, tt;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [E_W-1:0]    vec_a, vec_b;
  logic signed [PQ_W-1:0]   wide_b;
  logic signed [SUM_W-1:0]  margin;
  logic signed [DIV_W-1:0]  num, lim, sat_diff;
  logic signed [DIV_W-1:0]  rem, dsh, trial;
  logic [DIST_W-1:0]        quot;

  // operand selection
  always_comb begin
    unique case (cmd.uop.src_a)
      SRC_D:   vec_a = E_W'(dir[cmd.uop.idx_a]);
      SRC_E1:  vec_a = e1[cmd.uop.idx_a];
      SRC_E2:  vec_a = e2[cmd.uop.idx_a];
      SRC_S:   vec_a = s[cmd.uop.idx_a];
      default: vec_a = '0;
    endcase
    unique case (cmd.uop.src_b)
      SRC_D:   vec_b = E_W'(dir[cmd.uop.idx_b]);
      SRC_E1:  vec_b = e1[cmd.uop.idx_b];
      SRC_E2:  vec_b = e2[cmd.uop.idx_b];
      SRC_S:   vec_b = s[cmd.uop.idx_b];
      default: vec_b = '0;
    endcase
    wide_b = (cmd.uop.src_b == SRC_Q) ? q[cmd.uop.idx_b] : p[cmd.uop.idx_b];
    mul_a  = MUL_W'(vec_a);
    unique case (cmd.uop.part)
      PART_LO: mul_b = $signed({1'b0, wide_b[LO_W-1:0]});
      PART_HI: mul_b = wide_b[PQ_W-1:LO_W];
      default: mul_b = MUL_W'(vec_b);
    endcase
  end

  // accumulate, high halves weighted by 2^LO_W
  always_comb begin
    prod_ext = ACC_W'(prod);
    term     = (cmd.uop.part == PART_HI) ? (prod_ext <<< LO_W) : prod_ext;
    if (cmd.uop.sub) begin
      term = -term;
    end
    acc_next = (cmd.uop.clr ? '0 : acc) + term;
  end

  // status after sign normalization
  always_comb begin
    margin    = SUM_W'(det) - (SUM_W'(uu) + SUM_W'(vv));
    stat.miss = (det == '0) || uu[ACC_W-1] || vv[ACC_W-1] || tt[ACC_W-1]
                || margin[SUM_W-1];
    num       = DIV_W'(tt) <<< FRAC_BITS;
    lim       = DIV_W'(det) <<< DIST_W;
    sat_diff  = num - lim;
    stat.sat  = !sat_diff[DIV_W-1];
    trial     = rem - dsh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        org[i] <= '0;
        dir[i] <= '0;
        va[i]  <= '0;
        vb[i]  <= '0;
      end
    end else if (cmd.load) begin
      unique case (in_data.kind)
        KIND_ORIGIN: begin
          org[0] <= in_data.x; org[1] <= in_data.y; org[2] <= in_data.z;
        end
        KIND_DIR: begin
          dir[0] <= in_data.x; dir[1] <= in_data.y; dir[2] <= in_data.z;
        end
        KIND_A: begin
          va[0] <= in_data.x; va[1] <= in_data.y; va[2] <= in_data.z;
        end
        KIND_B: begin
          vb[0] <= in_data.x; vb[1] <= in_data.y; vb[2] <= in_data.z;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_data.kind == KIND_C) begin
      vc[0] <= in_data.x;
      vc[1] <= in_data.y;
      vc[2] <= in_data.z;
    end
    if (cmd.setup) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= E_W'(vb[i]) - E_W'(va[i]);
        e2[i] <= E_W'(vc[i]) - E_W'(va[i]);
        s[i]  <= E_W'(org[i]) - E_W'(va[i]);
      end
    end
    if (cmd.mul) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.acc) begin
      acc <= acc_next;
      unique case (cmd.uop.dst)
        DST_P:   p[cmd.uop.idx_d] <= PQ_W'(acc_next);
        DST_Q:   q[cmd.uop.idx_d] <= PQ_W'(acc_next);
        DST_DET: det <= acc_next;
        DST_UU:  uu  <= acc_next;
        DST_VV:  vv  <= acc_next;
        DST_TT:  tt  <= acc_next;
        default: ;
      endcase
    end
    if (cmd.norm && det[ACC_W-1]) begin
      det <= -det;
      uu  <= -uu;
      vv  <= -vv;
      tt  <= -tt;
    end
    if (cmd.div_init) begin
      rem  <= num;
      dsh  <= DIV_W'(det) <<< (DIST_W - 1);
      quot <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[DIV_W-1]) begin
        rem <= trial;
      end
      quot <= {quot[DIST_W-2:0], !trial[DIV_W-1]};
      dsh  <= dsh >>> 1;
    end
    if (cmd.out_load) begin
      out_data.hit <= !stat.miss;
      if (stat.miss) begin
        out_data.distance <= '0;
      end else if (stat.sat) begin
        out_data.distance <= '1;
      end else begin
        out_data.distance <= quot;
      end
    end
  end

endmodule

/* rtl/ray_triangle_intersect.sv */
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// fixed-point ray / triangle test by cramer's rule, one shared multiplier
// ----------------------------------------------------------------------------
//
//  channel | signals                       | beat carries
//  --------+-------------------------------+--------------------------------
//  in      | in_valid, in_ready, in_data   | kind and x, y, z (Q16.16)
//  out     | out_valid, out_ready, out_data| hit and distance t (Q15.16)
//
//  loads (kinds 0..3, and unused kinds 5..7) leave the sequencer idle; a solve
//  (kind 4) runs setup, the 36 products of the shared 34x34 multiplier and
//  accumulator, and unless it misses or saturates the restoring divider; the
//  input is ready only while the sequencer is idle; a finished result waits
//  in the output register, and a later solve holds until it is taken; reset
//  (rst, synchronous) clears origin, direction and vertices a, b to zero
// ----------------------------------------------------------------------------
module ray_triangle_intersect
  import rti_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: micro-op step, divider count, result handshake
  rti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // vector storage, multiply-accumulate, tests and divider
  rti_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

/* tb/ray_triangle_intersect_tb.sv */
// ----------------------------------------------------------------------------
// ray_triangle_intersect_tb
// self-checking bench for the fixed-point ray / triangle tester
//
// beats of kind origin, direction, vertex a/b/c (and unused kinds) are queued
// by a stimulus process, then sent by a clocked driver with random gaps.
// a behavioral solver at full precision predicts hit and distance for each
// accepted vertex c beat; a clocked monitor with random stalls compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_triangle_intersect_tb;
  import rti_pkg::*;

  typedef logic signed [255:0] big_t;

  localparam int  NUM_ITEMS = 750;
  localparam big_t DIST_LIMIT = (big_t'(1) <<< DIST_W) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  ray_triangle_intersect u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // beats waiting to be sent, and solve results still owed by the block
  in_t  send_q[$];
  out_t hit_q[$];
  int   err_cnt = 0;
  int   sent_cnt = 0;
  int   solve_cnt = 0;

  // shadow of the block's ray and vertex registers
  logic signed [COORD_W-1:0] sh_org[3];
  logic signed [COORD_W-1:0] sh_dir[3];
  logic signed [COORD_W-1:0] sh_a[3];
  logic signed [COORD_W-1:0] sh_b[3];

  // exact moller-trumbore at 256 bits, so no rounding reaches the decision
  function automatic out_t solve_hit(input logic signed [COORD_W-1:0] vc[3]);
    big_t e1[3], e2[3], s[3], d[3], p[3], q[3];
    big_t det, uu, vv, tt, quo;
    out_t r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = big_t'(sh_b[i]) - big_t'(sh_a[i]);
      e2[i] = big_t'(vc[i]) - big_t'(sh_a[i]);
      s[i]  = big_t'(sh_org[i]) - big_t'(sh_a[i]);
      d[i]  = big_t'(sh_dir[i]);
    end
    p[0] = d[1] * e2[2] - d[2] * e2[1];
    p[1] = d[2] * e2[0] - d[0] * e2[2];
    p[2] = d[0] * e2[1] - d[1] * e2[0];
    det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
    if (det == 0) return r;
    uu = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    vv = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    tt = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    if (det < 0) begin
      det = -det; uu = -uu; vv = -vv; tt = -tt;
    end
    if (uu < 0 || vv < 0 || tt < 0 || uu + vv > det) return r;
    quo = (tt <<< FRAC_BITS) / det;
    r.hit = 1'b1;
    r.distance = (quo > DIST_LIMIT) ? {DIST_W{1'b1}} : quo[DIST_W-1:0];
    return r;
  endfunction

  // update the shadow registers for one accepted beat
  function automatic void apply_beat(input in_t b);
    logic signed [COORD_W-1:0] v[3];
    v[0] = b.x; v[1] = b.y; v[2] = b.z;
    case (b.kind)
      KIND_ORIGIN: sh_org = v;
      KIND_DIR:    sh_dir = v;
      KIND_A:      sh_a = v;
      KIND_B:      sh_b = v;
      KIND_C: begin
        hit_q.push_back(solve_hit(v));
        solve_cnt++;
      end
      default: ;  // unused kinds leave everything alone
    endcase
  endfunction

  // gap length: mostly short, a few long, and whole stretches with none
  function automatic int pick_gap(input int phase);
    int r;
    if ((phase / 64) % 3 == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver: one nonblocking write per signal per edge
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sh_org[i] = '0; sh_dir[i] = '0; sh_a[i] = '0; sh_b[i] = '0;
      end
    end else begin
      if (in_valid && in_ready) begin
        apply_beat(in_data);
        sent_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (send_q.size() > 0) begin
          in_data <= send_q.pop_front();
          in_valid <= 1'b1;
          in_gap <= pick_gap(sent_cnt);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat, stall at random
  int out_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    out_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (hit_q.size() == 0) begin
          $error("result beat with nothing expected: hit=%0d distance=%0d",
                 out_data.hit, out_data.distance);
          err_cnt++;
        end else begin
          exp_r = hit_q.pop_front();
          if (out_data.hit !== exp_r.hit) begin
            $error("hit: expected %0d actual %0d", exp_r.hit, out_data.hit);
            err_cnt++;
          end
          if (out_data.distance !== exp_r.distance) begin
            $error("distance: expected %0d actual %0d", exp_r.distance,
                   out_data.distance);
            err_cnt++;
          end
        end
      end
      // long hold-off while the sender keeps going, so the block backs up
      if (!hold_done && solve_cnt >= 40) begin
        hold_done <= 1'b1;
        hold_left <= 3000;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap <= pick_gap(solve_cnt * 5);
      end
    end
  end

  task automatic put_beat(input logic [KIND_W-1:0] k, input logic [31:0] x,
                          input logic [31:0] y, input logic [31:0] z);
    in_t b;
    b.kind = k; b.x = x; b.y = y; b.z = z;
    send_q.push_back(b);
  endtask

  function automatic logic [31:0] rnd_coord(input int mag);
    return $signed($urandom_range(0, (1 << mag) - 1)) - (1 << (mag - 1));
  endfunction

  // a triangle aimed at by construction; weights out of range give misses,
  // a zero weight lands on an edge, a right shift of the direction grows t
  task automatic put_aimed(input int mag);
    longint va[3], vb[3], vc[3], o[3], tgt[3], dv[3];
    int w1, w2, sh;
    for (int i = 0; i < 3; i++) begin
      va[i] = longint'($signed(rnd_coord(mag)));
      vb[i] = longint'($signed(rnd_coord(mag)));
      vc[i] = longint'($signed(rnd_coord(mag)));
      o[i]  = longint'($signed(rnd_coord(mag)));
    end
    w1 = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(0, 256);
    w2 = $urandom_range(0, 256 - w1);
    if ($urandom_range(0, 5) == 0) w2 = 300;
    sh = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      tgt[i] = (va[i] * (256 - w1 - w2) + vb[i] * w1 + vc[i] * w2) / 256;
      dv[i] = (tgt[i] - o[i]) >>> sh;
      if ($urandom_range(0, 7) == 0) dv[i] = -dv[i];
    end
    put_beat(KIND_ORIGIN, 32'(o[0]), 32'(o[1]), 32'(o[2]));
    put_beat(KIND_DIR, 32'(dv[0]), 32'(dv[1]), 32'(dv[2]));
    put_beat(KIND_A, 32'(va[0]), 32'(va[1]), 32'(va[2]));
    put_beat(KIND_B, 32'(vb[0]), 32'(vb[1]), 32'(vb[2]));
    put_beat(KIND_C, 32'(vc[0]), 32'(vc[1]), 32'(vc[2]));
  endtask

  localparam logic [31:0] CMAX = 32'h7fff_ffff;
  localparam logic [31:0] CMIN = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;

  initial begin
    int r;
    // zero state after reset: determinant zero
    put_beat(KIND_C, '0, '0, '0);
    // unit triangle in the z=0 plane, ray from z=+1 looking down
    put_beat(KIND_ORIGIN, 32'h0000_4000, 32'h0000_4000, ONE);
    put_beat(KIND_DIR, '0, '0, -ONE);
    put_beat(KIND_A, '0, '0, '0);
    put_beat(KIND_B, ONE, '0, '0);
    put_beat(KIND_C, '0, ONE, '0);
    // vertex order swapped: negative determinant
    put_beat(KIND_B, '0, ONE, '0);
    put_beat(KIND_C, ONE, '0, '0);
    // origin on the plane: t exactly zero
    put_beat(KIND_ORIGIN, 32'h0000_4000, 32'h0000_4000, '0);
    put_beat(KIND_C, ONE, '0, '0);
    // hit on an edge, x=0
    put_beat(KIND_ORIGIN, '0, 32'h0000_4000, ONE);
    put_beat(KIND_C, ONE, '0, '0);
    // ray pointing away: negative t
    put_beat(KIND_DIR, '0, '0, ONE);
    put_beat(KIND_C, ONE, '0, '0);
    // tiny direction, huge t: saturation
    put_beat(KIND_ORIGIN, 32'h0000_4000, 32'h0000_4000, CMAX);
    put_beat(KIND_DIR, '0, '0, 32'hffff_ffff);
    put_beat(KIND_C, ONE, '0, '0);
    // unused kinds must not disturb anything
    put_beat(3'd5, CMAX, CMIN, CMAX);
    put_beat(3'd6, CMIN, CMAX, CMIN);
    put_beat(3'd7, '1, '1, '1);
    put_beat(KIND_C, ONE, '0, '0);
    // full-scale coordinates
    put_beat(KIND_ORIGIN, CMIN, CMAX, CMIN);
    put_beat(KIND_DIR, CMAX, CMAX, CMIN);
    put_beat(KIND_A, CMAX, CMIN, CMAX);
    put_beat(KIND_C, CMIN, CMIN, CMAX);

    while (send_q.size() < NUM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        put_aimed($urandom_range(0, 4) == 0 ? 30 : $urandom_range(4, 20));
      end else if (r < 90) begin
        // single beat of any kind with full-range content
        put_beat(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
      end else begin
        // broken sequence: a solve with only some operands refreshed
        put_beat(3'($urandom_range(0, 3)), rnd_coord(18), rnd_coord(18),
                 rnd_coord(18));
        put_beat(KIND_C, rnd_coord(18), rnd_coord(18), rnd_coord(18));
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    wait (send_q.size() == 0 && !in_valid && hit_q.size() == 0);
    repeat (300) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // safety net against a hung handshake
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
